/* sv/lsq_pkg.sv */
// Package for the linear-scan priority queue: sizes, codes and beat types.
`default_nettype none
package lsq_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int WORD_W   = KEY_W + VAL_W;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_PEEK     = 3'd1,
    FN_EXTRACT  = 3'd2,
    FN_DECREASE = 3'd3,
    FN_DELETE   = 3'd4
  } lsq_func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_BADH  = 3'd3,
    ST_INC   = 3'd4
  } lsq_status_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [KEY_W-1:0]  key;
    logic [VAL_W-1:0]         value;
    logic [3:0]               handle;
  } lsq_in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [KEY_W-1:0]  out_key;
    logic [VAL_W-1:0]         out_value;
    logic [3:0]               out_handle;
    logic [4:0]               occupancy;
  } lsq_out_t;

  typedef struct packed {
    logic                     found;
    logic signed [KEY_W-1:0]  key;
    logic [VAL_W-1:0]         value;
    logic [SLOT_W-1:0]        slot;
  } lsq_best_t;

endpackage
`default_nettype wire

/* sv/linear_scan_priority_queue.sv */
// Top level: request sequencer, slot valid bits and result register of the queue.
// Usage:
//   Requests enter on in_data, taken at a rising edge with start high and busy low.
//   Each request gives exactly one result beat on out_data, marked by out_valid for
//   one cycle; the receiver cannot stall, so the beat must be taken when shown.
//   Insert, empty or full cases, bad handles and unknown functions: result registered
//   at the accepting edge; busy stays low, so a request may follow every cycle.
//   Decrease and delete: one RAM read at the handle, then S_LOOK loads the result.
//   Peek and extract: the shared comparator walks all CAPACITY slots, one RAM read
//   per cycle, then passes through S_DRAIN and S_REPORT before the result beat;
//   busy stays high until the result register is loaded, so the next request is
//   taken at the earliest while the result beat is shown.
//   Keys and values sit in a single-port-write RAM; valid bits and the entry count
//   are flip-flops. Synchronous reset (rst_n low) empties the queue at once and
//   drops any request in flight; no clearing pass is needed.
`default_nettype none
module linear_scan_priority_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire lsq_pkg::lsq_in_t  in_data,
  output logic                   out_valid,
  output lsq_pkg::lsq_out_t      out_data
);

  localparam int SW = lsq_pkg::SLOT_W;
  localparam int CW = lsq_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_REPORT = 5'b01000,
    S_LOOK   = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  lsq_pkg::lsq_in_t               req_r, req_nxt;
  logic [SW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [SW-1:0]                  pend_idx_r, pend_idx_nxt;
  logic [lsq_pkg::CAPACITY-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  lsq_pkg::lsq_out_t              out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           ram_we;
  logic [SW-1:0]                  ram_waddr;
  logic [lsq_pkg::WORD_W-1:0]     ram_wdata;
  logic [SW-1:0]                  ram_raddr;
  logic [lsq_pkg::WORD_W-1:0]     ram_rdata;
  logic signed [lsq_pkg::KEY_W-1:0] rd_key;
  logic [lsq_pkg::VAL_W-1:0]      rd_value;

  logic                           scan_clr;
  logic                           scan_en;
  lsq_pkg::lsq_best_t             best;

  logic                           accept;
  logic [SW-1:0]                  in_slot;
  logic                           in_handle_ok;
  logic [SW-1:0]                  req_slot;
  logic [SW-1:0]                  free_slot;
  logic                           full;

  function automatic logic [SW-1:0] lowest_free(input logic [lsq_pkg::CAPACITY-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = lsq_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = SW'(i);
      end
    end
    return idx;
  endfunction

  assign accept       = start && !busy;
  assign in_slot      = SW'(in_data.handle);
  assign in_handle_ok = (int'(in_data.handle) < lsq_pkg::CAPACITY) && valid_r[in_slot];
  assign req_slot     = SW'(req_r.handle);
  assign free_slot    = lowest_free(valid_r);
  assign full         = &valid_r;
  assign rd_key       = ram_rdata[lsq_pkg::WORD_W-1 -: lsq_pkg::KEY_W];
  assign rd_value     = ram_rdata[lsq_pkg::VAL_W-1:0];
  assign scan_en      = pend_r && valid_r[pend_idx_r];
  assign ram_raddr    = (state_r == S_SCAN) ? rd_idx_r : in_slot;

  lsq_slot_ram #(
    .DEPTH (lsq_pkg::CAPACITY),
    .WIDTH (lsq_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsq_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (scan_clr),
    .cmp_en     (scan_en),
    .cand_key   (rd_key),
    .cand_value (rd_value),
    .cand_slot  (pend_idx_r),
    .best       (best)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = rd_idx_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = free_slot;
    ram_wdata     = {in_data.key, in_data.value};
    scan_clr      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt             = in_data;
          out_nxt             = '0;
          out_nxt.status      = lsq_pkg::ST_OK;
          out_nxt.occupancy   = 5'(count_r);
          case (in_data.func)
            lsq_pkg::FN_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.status = lsq_pkg::ST_FULL;
              end else begin
                ram_we                = 1'b1;
                valid_nxt[free_slot]  = 1'b1;
                count_nxt             = count_r + CW'(1);
                out_nxt.out_handle    = 4'(free_slot);
                out_nxt.occupancy     = 5'(count_r + CW'(1));
              end
            end
            lsq_pkg::FN_PEEK, lsq_pkg::FN_EXTRACT: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = lsq_pkg::ST_EMPTY;
              end else begin
                scan_clr   = 1'b1;
                rd_idx_nxt = '0;
                state_nxt  = S_SCAN;
              end
            end
            lsq_pkg::FN_DECREASE, lsq_pkg::FN_DELETE: begin
              out_nxt.out_handle = in_data.handle;
              if (!in_handle_ok) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = lsq_pkg::ST_BADH;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = rd_idx_r;
        rd_idx_nxt   = rd_idx_r + SW'(1);
        if (rd_idx_r == SW'(lsq_pkg::CAPACITY - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        out_valid_nxt      = 1'b1;
        out_nxt.out_key    = best.key;
        out_nxt.out_value  = best.value;
        out_nxt.out_handle = 4'(best.slot);
        out_nxt.occupancy  = 5'(count_r);
        if (req_r.func == lsq_pkg::FN_EXTRACT) begin
          valid_nxt[best.slot] = 1'b0;
          count_nxt            = count_r - CW'(1);
          out_nxt.occupancy    = 5'(count_r - CW'(1));
        end
        state_nxt = S_IDLE;
      end
      S_LOOK: begin
        out_valid_nxt     = 1'b1;
        out_nxt.out_key   = rd_key;
        out_nxt.out_value = rd_value;
        if (req_r.func == lsq_pkg::FN_DECREASE) begin
          if (req_r.key > rd_key) begin
            out_nxt.status = lsq_pkg::ST_INC;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = req_slot;
            ram_wdata       = {req_r.key, rd_value};
            out_nxt.out_key = req_r.key;
          end
        end else begin
          valid_nxt[req_slot] = 1'b0;
          count_nxt           = count_r - CW'(1);
          out_nxt.occupancy   = 5'(count_r - CW'(1));
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_r)))
    else $error("entry count disagrees with valid bits");

  a_report_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT || state_r == S_LOOK) |=> (out_valid && !busy))
    else $error("missing result beat");

  a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT) |-> best.found)
    else $error("scan of nonempty queue found nothing");

endmodule
`default_nettype wire

/* sv/lsq_slot_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/lsq_scan.sv */
// Minimum-search unit: one signed comparator keeps the running best slot.
`default_nettype none
module lsq_scan (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              clr,
  input  wire logic                              cmp_en,
  input  wire logic signed [lsq_pkg::KEY_W-1:0]  cand_key,
  input  wire logic [lsq_pkg::VAL_W-1:0]         cand_value,
  input  wire logic [lsq_pkg::SLOT_W-1:0]        cand_slot,
  output lsq_pkg::lsq_best_t                     best
);

  logic               found_r, found_nxt;
  lsq_pkg::lsq_best_t data_r, data_nxt;
  logic               take;

  // strict less-than: slots arrive in ascending order, so ties keep the lower slot
  assign take = cmp_en && (!found_r || (cand_key < data_r.key));

  always_comb begin
    found_nxt = found_r;
    data_nxt  = data_r;
    if (clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt      = 1'b1;
      data_nxt.key   = cand_key;
      data_nxt.value = cand_value;
      data_nxt.slot  = cand_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    best       = data_r;
    best.found = found_r;
  end

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> !found_r)
    else $error("scan best not cleared");

  a_first_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_en && !clr && !found_r) |=> (found_r && data_r.slot == $past(cand_slot)))
    else $error("first candidate not taken");

  a_never_worse: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !clr) |=> (found_r && data_r.key <= $past(data_r.key)))
    else $error("scan best grew");

endmodule
`default_nettype wire
